FILE: sv/ofms_pkg.sv
// Package for the fold-map stencil: shared constants, opcodes and the grid port types.
package ofms_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int DISP_W        = 16;
    localparam int THR_W         = 13;
    localparam int FOLD_W        = 8;

    localparam logic [THR_W-1:0] THRESH_RESET = 13'd3686;

    // Input opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One grid entry: both horizontal displacements, signed Q3.13.
    typedef struct packed {
        logic signed [DISP_W-1:0] x;
        logic signed [DISP_W-1:0] z;
    } t_disp_pair;

    // Control of the single grid memory port.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_grid_ctl;

endpackage

FILE: sv/ofms_grid.sv
// Single-port displacement grid memory with registered read data.
module ofms_grid #(
    parameter int GRID_SIZE = ofms_pkg::GRID_SIZE_DEF
) (
    input  logic                                      i_clk,
    input  ofms_pkg::t_grid_ctl                       i_ctl,
    input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]    i_addr,
    input  ofms_pkg::t_disp_pair                      i_wdata,
    output ofms_pkg::t_disp_pair                      o_rdata
);
    import ofms_pkg::*;

    localparam int DEPTH = GRID_SIZE * GRID_SIZE;

    t_disp_pair r_mem [DEPTH];
    t_disp_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ocean_fold_map_stencil.sv
// Top level of the whitecap fold-map stencil: sequencer, shared multiplier and output register.
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall       i_opcode i_row i_col i_x_disp i_z_disp
//   result    out        o_valid / i_stall       o_fold_value
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_data (fold threshold)
//
// A write request does not stall the input. A query keeps the input stalled once it is accepted,
// while it steps through four reads through the single grid memory port, one to form the second
// difference, two passes through the one shared 18x18 multiplier, one subtract and one to
// scale into the output register. The next query is taken only once the sequencer is idle again.
// Reset clears the sequencer, the output valid and sets the threshold to its default.
// A finished query waits in its last step while the previous result is still stalled.
module ocean_fold_map_stencil #(
    parameter int GRID_SIZE = ofms_pkg::GRID_SIZE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_opcode,
    input  logic [$clog2(GRID_SIZE)-1:0]          i_row,
    input  logic [$clog2(GRID_SIZE)-1:0]          i_col,
    input  logic signed [ofms_pkg::DISP_W-1:0]    i_x_disp,
    input  logic signed [ofms_pkg::DISP_W-1:0]    i_z_disp,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ofms_pkg::FOLD_W-1:0]           o_fold_value,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ofms_pkg::THR_W-1:0]            i_cfg_data
);
    import ofms_pkg::*;

    localparam int IDX_W    = $clog2(GRID_SIZE);
    localparam int ADDR_W   = $clog2(GRID_SIZE * GRID_SIZE);
    localparam int DIFF_W   = DISP_W + 1;
    localparam int OPND_W   = DISP_W + 2;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int MARGIN_W = PROD_W + 2;
    localparam int FRAC_W   = 26;
    localparam int THR_SH   = 14;

    localparam logic [IDX_W:0]    G_EXT = (IDX_W+1)'(GRID_SIZE);
    localparam logic [IDX_W-1:0]  G_MAX = IDX_W'(GRID_SIZE - 1);
    localparam logic signed [OPND_W-1:0] ONE_Q13 = OPND_W'(8192);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_RD3  = 4'd4;
    localparam logic [3:0] S_DIFB = 4'd5;
    localparam logic [3:0] S_MUL1 = 4'd6;
    localparam logic [3:0] S_MUL2 = 4'd7;
    localparam logic [3:0] S_SUB  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]                  r_state, n_state;
    logic [IDX_W-1:0]            r_row;
    logic [IDX_W-1:0]            r_col;
    logic signed [DISP_W-1:0]    r_tmp;
    logic signed [DIFF_W-1:0]    r_a;
    logic signed [DIFF_W-1:0]    r_b;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [PROD_W-1:0]    r_sq;
    logic signed [MARGIN_W-1:0]  r_margin;
    logic [THR_W-1:0]            r_thr;
    logic                        r_out_valid;
    logic [FOLD_W-1:0]           r_fold;

    logic                        in_acc;
    logic                        out_free;
    logic [IDX_W:0]              row_ext;
    logic [IDX_W:0]              col_ext;
    logic [IDX_W-1:0]            row_red;
    logic [IDX_W-1:0]            col_red;
    logic [IDX_W-1:0]            row_p, row_m, col_p, col_m;
    logic [IDX_W-1:0]            sel_row, sel_col;
    logic [ADDR_W-1:0]           addr;
    t_grid_ctl                   grid_ctl;
    t_disp_pair                  wdata;
    t_disp_pair                  rdata;
    logic signed [OPND_W-1:0]    op_a, op_b;
    logic signed [PROD_W-1:0]    mult;
    logic [FRAC_W-1:0]           m_frac;
    logic [FRAC_W+FOLD_W-1:0]    scaled;
    logic [FOLD_W-1:0]           fold;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // Rows and columns at or beyond the grid size wrap once.
    always_comb begin
        row_ext = {1'b0, i_row};
        col_ext = {1'b0, i_col};
        if (row_ext >= G_EXT) begin
            row_ext = row_ext - G_EXT;
        end
        if (col_ext >= G_EXT) begin
            col_ext = col_ext - G_EXT;
        end
        row_red = row_ext[IDX_W-1:0];
        col_red = col_ext[IDX_W-1:0];
    end

    assign row_p = (r_row == G_MAX) ? '0 : r_row + 1'b1;
    assign row_m = (r_row == '0) ? G_MAX : r_row - 1'b1;
    assign col_p = (r_col == G_MAX) ? '0 : r_col + 1'b1;
    assign col_m = (r_col == '0) ? G_MAX : r_col - 1'b1;

    always_comb begin
        grid_ctl = '0;
        sel_row  = row_red;
        sel_col  = col_red;
        case (r_state)
            S_IDLE: begin
                grid_ctl.wr_en = in_acc && (i_opcode == OP_WRITE);
            end
            S_RD0: begin
                grid_ctl.rd_en = 1'b1;
                sel_row        = row_p;
                sel_col        = r_col;
            end
            S_RD1: begin
                grid_ctl.rd_en = 1'b1;
                sel_row        = row_m;
                sel_col        = r_col;
            end
            S_RD2: begin
                grid_ctl.rd_en = 1'b1;
                sel_row        = r_row;
                sel_col        = col_m;
            end
            S_RD3: begin
                grid_ctl.rd_en = 1'b1;
                sel_row        = r_row;
                sel_col        = col_p;
            end
            default: begin
                grid_ctl = '0;
            end
        endcase
        addr = ADDR_W'(sel_row) * ADDR_W'(GRID_SIZE) + ADDR_W'(sel_col);
    end

    assign wdata.x = i_x_disp;
    assign wdata.z = i_z_disp;

    ofms_grid #(
        .GRID_SIZE (GRID_SIZE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_ctl   (grid_ctl),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    // The one multiplier forms (1+a)(1+b) first and b*b on the next pass.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            S_MUL1: begin
                op_a = {r_a[DIFF_W-1], r_a} + ONE_Q13;
                op_b = {r_b[DIFF_W-1], r_b} + ONE_Q13;
            end
            S_MUL2: begin
                op_a = {r_b[DIFF_W-1], r_b};
                op_b = {r_b[DIFF_W-1], r_b};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        mult = op_a * op_b;
    end

    // Margin below one in Q.26 is scaled by 255 as a shift and subtract.
    always_comb begin
        m_frac = r_margin[FRAC_W-1:0];
        scaled = {m_frac, {FOLD_W{1'b0}}} - (FRAC_W+FOLD_W)'(m_frac);
        if (r_margin[MARGIN_W-1] || (r_margin == '0)) begin
            fold = '0;
        end else if (r_margin[MARGIN_W-2:FRAC_W] != '0) begin
            fold = '1;
        end else begin
            fold = scaled[FRAC_W+FOLD_W-1:FRAC_W];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_QUERY)) begin
                    n_state = S_RD0;
                end
            end
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_DIFB;
            S_DIFB: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUB;
            S_SUB:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= THRESH_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row <= row_red;
            r_col <= col_red;
        end
        case (r_state)
            S_RD1: r_tmp <= rdata.x;
            S_RD2: r_a   <= {r_tmp[DISP_W-1], r_tmp} - {rdata.x[DISP_W-1], rdata.x};
            S_RD3: r_tmp <= rdata.z;
            S_DIFB: r_b  <= {r_tmp[DISP_W-1], r_tmp} - {rdata.z[DISP_W-1], rdata.z};
            S_MUL1: r_prod <= mult;
            S_MUL2: r_sq   <= mult;
            S_SUB: begin
                r_margin <= {{(MARGIN_W-PROD_W){r_prod[PROD_W-1]}}, r_prod}
                          - {{(MARGIN_W-PROD_W){r_sq[PROD_W-1]}}, r_sq}
                          - {{(MARGIN_W-THR_W-THR_SH){1'b0}}, r_thr, {THR_SH{1'b0}}};
            end
            S_FIN: begin
                if (out_free) begin
                    r_fold <= fold;
                end
            end
            default: begin
                r_tmp <= r_tmp;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_fold_value = r_fold;

endmodule
